FILE: rtl/itc_pkg.sv
// itc_pkg: shared constants for the interval timer channel (modes 0 and 2)
// holds word kind codes, control word fields and the counter width
// no dependencies
package itc_pkg;

  // width of the counting element and its reload register
  localparam int unsigned COUNT_BITS = 16;

  // width of the result count port
  localparam int unsigned COUNT_OUT_BITS = 16;

  // word kind codes
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_CTRL  = 2'd1;
  localparam logic [1:0] KIND_COUNT = 2'd2;

  // control word: channel 0 with low/high byte access in bits 7..4
  localparam logic [3:0] CW_HEAD_OK = 4'h3;

  // control word mode field codes
  localparam logic [2:0] MODE_TERMINAL = 3'd0;
  localparam logic [2:0] MODE_RATE     = 3'd2;
  localparam logic [2:0] MODE_RATE_ALT = 3'd6;

endpackage

FILE: rtl/interval_timer_channel_mode0_mode2.sv
// interval_timer_channel_mode0_mode2: one timer counter channel, modes 0 and 2
// binary counting, low byte then high byte access
// depends on itc_pkg
//
// usage:
//   input channel (in_valid_i / in_ready_o) carries one word per item:
//   kind_i selects an input clock tick, a control word write or a count
//   byte write; data_byte_i holds the written byte.
//   output channel (out_valid_o / out_ready_i) returns one word per input
//   word: output pin level, a rise flag, the counting element value and a
//   flag for a rejected control word.
//   the result is registered, valid in the cycle after the word is taken.
//   throughput: one word per cycle while results are read out; the channel
//   state is updated by a single level of logic at acceptance and the
//   result sits in one output register.
//   stall: while a result waits unread, a new word is still taken in the
//   same cycle that the waiting result is read; otherwise in_ready_o drops.
//   reset: mode 0, low byte next, counter stopped at zero, output pin high,
//   output register empty.
module interval_timer_channel_mode0_mode2 (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          kind_i,
  input  logic [7:0]                          data_byte_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                out_level_o,
  output logic                                out_rose_o,
  output logic [itc_pkg::COUNT_OUT_BITS-1:0]  count_now_o,
  output logic                                write_rejected_o
);
  import itc_pkg::*;

  // channel state
  logic                  periodic_q, periodic_d;
  logic                  expect_high_q, expect_high_d;
  logic [7:0]            low_latch_q, low_latch_d;
  logic [COUNT_BITS-1:0] reload_q, reload_d;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic                  load_pending_q, load_pending_d;
  logic                  counting_q, counting_d;
  logic                  pin_q, pin_d;

  // result register
  logic                      out_valid_q;
  logic                      level_q, rose_q, rejected_q;
  logic [COUNT_OUT_BITS-1:0] count_out_q;
  logic                      rejected_d;

  logic                  accept;
  logic [COUNT_BITS-1:0] eff_reload;
  logic [COUNT_BITS-1:0] count_dec;
  logic [2:0]            cw_mode;

  // handshake: take a word whenever the result slot frees this cycle
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // reload as used by the counter: in mode 2 a count of one acts as two
  always_comb begin
    eff_reload = reload_q;
    if (periodic_q && (reload_q == COUNT_BITS'(1))) begin
      eff_reload = COUNT_BITS'(2);
    end
  end

  assign count_dec = count_q - COUNT_BITS'(1);
  assign cw_mode   = data_byte_i[3:1];

  // next channel state for the incoming word
  always_comb begin
    periodic_d     = periodic_q;
    expect_high_d  = expect_high_q;
    low_latch_d    = low_latch_q;
    reload_d       = reload_q;
    count_d        = count_q;
    load_pending_d = load_pending_q;
    counting_d     = counting_q;
    pin_d          = pin_q;
    rejected_d     = 1'b0;
    unique case (kind_i)
      KIND_TICK: begin
        if (load_pending_q && (!counting_q || !periodic_q)) begin
          // armed count loads without decrementing
          count_d        = eff_reload;
          load_pending_d = 1'b0;
          counting_d     = 1'b1;
        end else if (counting_q) begin
          if (!periodic_q) begin
            count_d = count_dec;
            if (count_dec == '0) begin
              pin_d = 1'b1;
            end
          end else if (count_q == COUNT_BITS'(1)) begin
            // end of period: reload and release the output
            count_d        = eff_reload;
            load_pending_d = 1'b0;
            pin_d          = 1'b1;
          end else begin
            count_d = count_dec;
            if (count_dec == COUNT_BITS'(1)) begin
              pin_d = 1'b0;
            end
          end
        end
      end
      KIND_CTRL: begin
        if (data_byte_i[7:4] != CW_HEAD_OK) begin
          rejected_d = 1'b1;
        end else if (cw_mode == MODE_TERMINAL) begin
          periodic_d     = 1'b0;
          pin_d          = 1'b0;
          expect_high_d  = 1'b0;
          load_pending_d = 1'b0;
          counting_d     = 1'b0;
        end else if ((cw_mode == MODE_RATE) || (cw_mode == MODE_RATE_ALT)) begin
          periodic_d     = 1'b1;
          pin_d          = 1'b1;
          expect_high_d  = 1'b0;
          load_pending_d = 1'b0;
          counting_d     = 1'b0;
        end else begin
          rejected_d = 1'b1;
        end
      end
      KIND_COUNT: begin
        if (!expect_high_q) begin
          low_latch_d   = data_byte_i;
          expect_high_d = 1'b1;
          if (!periodic_q) begin
            counting_d = 1'b0;
            pin_d      = 1'b0;
          end
        end else begin
          reload_d       = COUNT_BITS'({data_byte_i, low_latch_q});
          expect_high_d  = 1'b0;
          load_pending_d = 1'b1;
        end
      end
      default: begin
        // unused kind leaves the state alone
      end
    endcase
  end

  // channel state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      periodic_q     <= 1'b0;
      expect_high_q  <= 1'b0;
      low_latch_q    <= '0;
      reload_q       <= '0;
      count_q        <= '0;
      load_pending_q <= 1'b0;
      counting_q     <= 1'b0;
      pin_q          <= 1'b1;
    end else if (accept) begin
      periodic_q     <= periodic_d;
      expect_high_q  <= expect_high_d;
      low_latch_q    <= low_latch_d;
      reload_q       <= reload_d;
      count_q        <= count_d;
      load_pending_q <= load_pending_d;
      counting_q     <= counting_d;
      pin_q          <= pin_d;
    end
  end

  // result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      level_q     <= pin_d;
      rose_q      <= !pin_q && pin_d;
      count_out_q <= COUNT_OUT_BITS'(count_d);
      rejected_q  <= rejected_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_level_o      = level_q;
  assign out_rose_o       = rose_q;
  assign count_now_o      = count_out_q;
  assign write_rejected_o = rejected_q;

  // a rise always leaves the output high
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!out_rose_o || out_level_o))
    else $error("rise reported with output low");

  // a rejected control word cannot move the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && write_rejected_o) |-> !out_rose_o)
    else $error("rejected control word changed the output");

  // running in mode 2 the output is low exactly when the count sits at one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (periodic_q && counting_q) |-> (pin_q == (count_q != COUNT_BITS'(1))))
    else $error("rate generator output out of step with count");

  // every accepted word yields a result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted word produced no result");

endmodule
